// File: sv/eadc_pkg.sv
// ---------------------------------------------------------------------------
// eadc_pkg
// Types and constants shared by the energy-adaptive duty control block.
// ---------------------------------------------------------------------------
`default_nettype none

package eadc_pkg;

  localparam int LEVEL_W  = 16;
  localparam int K_W      = 16;
  localparam int MODE_W   = 2;
  localparam int METRIC_W = 40;
  localparam int CFG_W    = 40;
  localparam int CFG_IDX_W = 3;

  // serial divider: dividend wide enough for 2^32, divisor up to 16 bits
  localparam int DIV_N_W = 33;
  localparam int DIV_D_W = 16;
  localparam int DIV_CNT_W = 6;

  localparam logic [MODE_W-1:0] MODE_HOLD = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DEC  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_INC  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BETA_LOW  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BETA_HIGH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAMMA     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_K_MIN     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_K_STEP    = 3'd5;

  localparam logic        OP_INIT   = 1'b0;
  localparam logic        OP_UPDATE = 1'b1;

  localparam logic [METRIC_W-1:0] METRIC_MAX = {1'b0, {(METRIC_W-1){1'b1}}};
  localparam logic [METRIC_W-1:0] METRIC_MIN = {1'b1, {(METRIC_W-1){1'b0}}};

  typedef struct packed {
    logic                op;
    logic [LEVEL_W-1:0]  level;
  } eadc_sample_t;

  typedef struct packed {
    logic [K_W-1:0]      k_out;
    logic [MODE_W-1:0]   mode_out;
  } eadc_result_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic mul;
    logic metric_load;
    logic div_start;
    logic mode_load;
    logic commit;
  } eadc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic op;
    logic special;
    logic div_done;
  } eadc_status_t;

endpackage

`default_nettype wire

// File: sv/eadc_div.sv
// ---------------------------------------------------------------------------
// eadc_div
// Restoring serial divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module eadc_div
  import eadc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic [DIV_N_W-1:0]   dividend,
  input  wire logic [DIV_D_W-1:0]   divisor,
  output logic                      done,
  output logic [DIV_N_W-1:0]        quotient
);

  logic [DIV_N_W-1:0]   quo;
  logic [DIV_D_W-1:0]   rem;
  logic [DIV_D_W-1:0]   dvs;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;

  logic [DIV_D_W:0]     trial;
  logic [DIV_D_W:0]     diff;
  logic                 fits;

  always_comb begin
    trial = {rem, quo[DIV_N_W-1]};
    diff  = trial - {1'b0, dvs};
    fits  = (trial >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_N_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[DIV_N_W-2:0], fits};
      rem <= fits ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
    end
  end

  assign quotient = quo;

endmodule

`default_nettype wire

// File: sv/eadc_datapath.sv
// ---------------------------------------------------------------------------
// eadc_datapath
// Config registers, metric arithmetic, mode and factor state, result register.
// ---------------------------------------------------------------------------
`default_nettype none

module eadc_datapath
  import eadc_pkg::*;
#(
  parameter int DECREASE_DIVISOR = 2
)(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_W-1:0]      cfg_data,
  input  wire eadc_sample_t          sample,
  input  wire eadc_cmd_t             cmd,
  output eadc_status_t               status,
  output eadc_result_t               result
);

  localparam int PROD_W = 35;

  // ceil(k / d) as ((k + d - 1) * m) >> 21, exact for dividends below 2^17
  localparam int KDIV_SHIFT = 21;
  localparam int KDIV_M_W   = KDIV_SHIFT + 1;
  localparam int KDIV_P_W   = K_W + 1 + KDIV_M_W;
  localparam logic [KDIV_M_W-1:0] KDIV_M =
    KDIV_M_W'(((longint'(1) << KDIV_SHIFT) + longint'(DECREASE_DIVISOR) - 1) /
              longint'(DECREASE_DIVISOR));

  logic [LEVEL_W-1:0]  capacity;
  logic [METRIC_W-1:0] beta_low;
  logic [METRIC_W-1:0] beta_high;
  logic [LEVEL_W-1:0]  gamma_level;
  logic [K_W-1:0]      k_min;
  logic [K_W-1:0]      k_step;

  logic                op;
  logic [LEVEL_W-1:0]  level;
  logic [PROD_W-1:0]   prod;
  logic [METRIC_W-1:0] metric;
  logic [MODE_W-1:0]   mode;
  logic [K_W-1:0]      k_factor;
  logic [LEVEL_W-1:0]  prev_level;

  logic [DIV_N_W-1:0]  div_n;
  logic [DIV_D_W-1:0]  div_d;
  logic [DIV_N_W-1:0]  div_q;
  logic                div_done;

  logic                special;
  logic [LEVEL_W:0]    delta;
  logic [PROD_W-1:0]   prod_next;
  logic [METRIC_W:0]   t1_ext;
  logic [METRIC_W:0]   q_ext;
  logic [METRIC_W:0]   sum;
  logic [METRIC_W-1:0] metric_next;
  logic [MODE_W-1:0]   mode_next;
  logic [K_W:0]        k_bias;
  logic [KDIV_P_W-1:0] k_prod;
  logic [K_W-1:0]      k_quot;
  logic [K_W-1:0]      k_dec;
  logic [K_W:0]        k_sum;
  logic [K_W-1:0]      k_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity    <= 16'd256;
      beta_low    <= '0;
      beta_high   <= 40'd65536;
      gamma_level <= 16'hFFFF;
      k_min       <= 16'd1;
      k_step      <= 16'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CAPACITY:  capacity    <= cfg_data[LEVEL_W-1:0];
        REG_BETA_LOW:  beta_low    <= cfg_data[METRIC_W-1:0];
        REG_BETA_HIGH: beta_high   <= cfg_data[METRIC_W-1:0];
        REG_GAMMA:     gamma_level <= cfg_data[LEVEL_W-1:0];
        REG_K_MIN:     k_min       <= cfg_data[K_W-1:0];
        REG_K_STEP:    k_step      <= cfg_data[K_W-1:0];
        default: ;
      endcase
    end
  end

  // recip = 2^32 / level
  assign div_n = {1'b1, {(DIV_N_W-1){1'b0}}};
  assign div_d = level;

  eadc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    special   = (level > gamma_level) || (level == '0);
    delta     = {1'b0, level} - {1'b0, prev_level};
    prod_next = PROD_W'($signed({2'b00, capacity}) * $signed(delta));

    // floor divide by 256 is an arithmetic shift
    t1_ext = {{(METRIC_W + 1 - (PROD_W - 8)){prod[PROD_W-1]}}, prod[PROD_W-1:8]};
    q_ext  = (METRIC_W+1)'(div_q);
    sum    = t1_ext - q_ext + (METRIC_W+1)'(65536);

    if (special) begin
      metric_next = (level > gamma_level) ? METRIC_MAX : METRIC_MIN;
    end else if (sum[METRIC_W] != sum[METRIC_W-1]) begin
      metric_next = sum[METRIC_W] ? METRIC_MIN : METRIC_MAX;
    end else begin
      metric_next = sum[METRIC_W-1:0];
    end
  end

  always_comb begin
    mode_next = mode;
    case (mode)
      MODE_HOLD: begin
        if ($signed(metric) < $signed(beta_low)) begin
          mode_next = MODE_DEC;
        end else if ($signed(metric) > $signed(beta_high)) begin
          mode_next = MODE_INC;
        end
      end
      MODE_DEC: begin
        if ($signed(metric) > $signed(beta_low)) begin
          mode_next = MODE_HOLD;
        end
      end
      MODE_INC: begin
        if ($signed(metric) < $signed(beta_high)) begin
          mode_next = MODE_HOLD;
        end
      end
      default: mode_next = mode;
    endcase
  end

  always_comb begin
    k_bias = {1'b0, k_factor} + (K_W+1)'(DECREASE_DIVISOR - 1);
    k_prod = {{KDIV_M_W{1'b0}}, k_bias} * {{(K_W+1){1'b0}}, KDIV_M};
    k_quot = k_prod[KDIV_SHIFT +: K_W];
    k_dec  = (k_quot < k_min) ? k_min : k_quot;
    k_sum  = {1'b0, k_factor} + {1'b0, k_step};
    if (op == OP_INIT) begin
      k_next = k_min;
    end else if (mode == MODE_DEC) begin
      k_next = k_dec;
    end else if (mode == MODE_INC) begin
      k_next = k_sum[K_W] ? {K_W{1'b1}} : k_sum[K_W-1:0];
    end else begin
      k_next = k_factor;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_HOLD;
      k_factor   <= 16'd1;
      prev_level <= '0;
    end else begin
      if (cmd.mode_load) begin
        mode <= mode_next;
      end
      if (cmd.commit) begin
        k_factor   <= k_next;
        prev_level <= level;
        if (op == OP_INIT) begin
          mode <= MODE_HOLD;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op    <= sample.op;
      level <= sample.level;
    end
    if (cmd.mul) begin
      prod <= prod_next;
    end
    if (cmd.metric_load) begin
      metric <= metric_next;
    end
    if (cmd.commit) begin
      result.k_out    <= k_next;
      result.mode_out <= (op == OP_INIT) ? MODE_HOLD : mode;
    end
  end

  assign status.op       = op;
  assign status.special  = special;
  assign status.div_done = div_done;

endmodule

`default_nettype wire

// File: sv/eadc_ctrl.sv
// ---------------------------------------------------------------------------
// eadc_ctrl
// Sequencer for one word at a time, plus the result valid flag.
// ---------------------------------------------------------------------------
`default_nettype none

module eadc_ctrl
  import eadc_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         sample_valid,
  output logic              sample_stall,
  output logic              result_valid,
  input  wire logic         result_stall,
  input  wire eadc_status_t status,
  output eadc_cmd_t         cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_RECIP  = 3'd2;
  localparam logic [2:0] S_MODE   = 3'd3;
  localparam logic [2:0] S_COMMIT = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_free;

  assign sample_stall = (state != S_IDLE);
  assign out_free     = !result_valid || !result_stall;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (sample_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.op == OP_INIT) begin
          state_next = S_COMMIT;
        end else if (status.special) begin
          cmd.metric_load = 1'b1;
          state_next      = S_MODE;
        end else begin
          cmd.mul       = 1'b1;
          cmd.div_start = 1'b1;
          state_next    = S_RECIP;
        end
      end
      S_RECIP: begin
        if (status.div_done) begin
          cmd.metric_load = 1'b1;
          state_next      = S_MODE;
        end
      end
      S_MODE: begin
        cmd.mode_load = 1'b1;
        state_next    = S_COMMIT;
      end
      S_COMMIT: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/energy_adaptive_duty_control.sv
// ---------------------------------------------------------------------------
// energy_adaptive_duty_control
// Adapts a duty factor k from battery-level samples through a three-state mode.
//
//   channel   signals                               word
//   sample    sample_valid / sample_stall / sample  eadc_sample_t (op, level)
//   result    result_valid / result_stall / result  eadc_result_t (k_out, mode_out)
//   config    cfg_we / cfg_index / cfg_data         40-bit register write
//
// init: the check state goes straight to commit, where k is set to k_min
// update: check, recip, mode and commit states, recip waiting on the 33-step
// serial divider for 2^32 / level; a level of zero or above gamma skips recip
// the decrease of k is a constant reciprocal multiply, done combinationally
// reset is synchronous and restores the register defaults and the state
// a new sample is taken while a result waits; its own result waits for the slot
// ---------------------------------------------------------------------------
`default_nettype none

module energy_adaptive_duty_control
  import eadc_pkg::*;
#(
  parameter int DECREASE_DIVISOR = 2
)(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  sample_valid,
  output logic                       sample_stall,
  input  wire eadc_sample_t          sample,
  output logic                       result_valid,
  input  wire logic                  result_stall,
  output eadc_result_t               result,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_W-1:0]      cfg_data
);

  eadc_cmd_t    cmd;
  eadc_status_t status;

  eadc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .cmd          (cmd)
  );

  eadc_datapath #(
    .DECREASE_DIVISOR (DECREASE_DIVISOR)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (sample),
    .cmd       (cmd),
    .status    (status),
    .result    (result)
  );

endmodule

`default_nettype wire
